[rtl/cpi_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpi_pkg
// Shared types, register map, reset values and command codes of the cascaded
// PI controller.
// ----------------------------------------------------------------------------
package cpi_pkg;

  localparam int SIG_W_DEFAULT = 32;
  localparam int IO_W          = 32;
  localparam int GAIN_W        = 32;
  localparam int DECAY_W       = 25;
  localparam int LIMIT_W       = 31;
  localparam int MUL_FRAC      = 24;
  localparam int CFG_IDX_W     = 8;
  localparam int CFG_DATA_W    = 32;
  localparam int IN_TDATA_W    = 3 * IO_W;
  localparam int OUT_TDATA_W   = 136;
  localparam int OUT_PAD_W     = OUT_TDATA_W - 4 * IO_W - 2;

  // register map
  localparam logic [CFG_IDX_W-1:0] REG_KP_OUTER       = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KP_OUTER_RECIP = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DECAY_OUTER    = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT_OUTER    = 8'd3;
  localparam logic [CFG_IDX_W-1:0] REG_KP_INNER       = 8'd4;
  localparam logic [CFG_IDX_W-1:0] REG_KP_INNER_RECIP = 8'd5;
  localparam logic [CFG_IDX_W-1:0] REG_DECAY_INNER    = 8'd6;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT_INNER    = 8'd7;

  // reset values
  localparam logic signed [GAIN_W-1:0] KP_OUTER_RST       = 32'sd838861;
  localparam logic signed [GAIN_W-1:0] KP_OUTER_RECIP_RST = 32'sd335544320;
  localparam logic [DECAY_W-1:0]       DECAY_OUTER_RST    = 25'd16777174;
  localparam logic [LIMIT_W-1:0]       LIMIT_OUTER_RST    = 31'd1966080;
  localparam logic signed [GAIN_W-1:0] KP_INNER_RST       = -32'sd838861;
  localparam logic signed [GAIN_W-1:0] KP_INNER_RECIP_RST = -32'sd335544320;
  localparam logic [DECAY_W-1:0]       DECAY_INNER_RST    = 25'd16777182;
  localparam logic [LIMIT_W-1:0]       LIMIT_INNER_RST    = 31'd262144;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_ERR,
    OP_DIFF,
    OP_MUL_RECIP,
    OP_MUL_DECAY,
    OP_MUL_KP,
    OP_ADD_PE,
    OP_SUB_E,
    OP_ADD_PUS,
    OP_COMMIT,
    OP_EMIT
  } cpi_op_t;

  typedef enum logic {
    LOOP_OUTER,
    LOOP_INNER
  } cpi_loop_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ERR,
    S_DIFF,
    S_MUL_R,
    S_WAIT_R,
    S_MUL_D,
    S_WAIT_D,
    S_MUL_K,
    S_WAIT_K,
    S_COMMIT,
    S_EMIT
  } cpi_state_t;

  typedef struct packed {
    cpi_op_t   op;
    cpi_loop_t loop;
  } cpi_cmd_t;

  typedef struct packed {
    logic mul_busy;
    logic out_free;
  } cpi_status_t;

endpackage

[rtl/cpi_mul.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpi_mul
// Sequential Q8.24 gain by signal multiplier: 32-bit chunks of the signal
// magnitude, round half away from zero, saturate to the signal width.
// ----------------------------------------------------------------------------
module cpi_mul import cpi_pkg::*; #(
  parameter int W = SIG_W_DEFAULT
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic signed [GAIN_W-1:0] gain,
  input  logic signed [W-1:0]      sig,
  output logic                     busy,
  output logic signed [W-1:0]      prod
);

  localparam int NCHUNK = (W + 31) / 32;
  localparam int MSW    = NCHUNK * 32;
  localparam int AW     = GAIN_W + MSW;
  localparam int QW     = AW - MUL_FRAC;
  localparam int CW     = $clog2(NCHUNK + 2);
  localparam logic [CW-1:0] CNT_START  = CW'(NCHUNK + 1);
  localparam logic [AW-1:0] ROUND_HALF = AW'(1) << (MUL_FRAC - 1);
  localparam logic [QW-1:0] Q_HALF     = QW'(1) << (W - 1);
  localparam logic [QW-1:0] Q_MAX      = Q_HALF - QW'(1);
  localparam logic [W-1:0]  MAXW       = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0]  MINW       = {1'b1, {(W-1){1'b0}}};

  logic              busy_r, busy_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [GAIN_W-1:0] mg_r;
  logic [MSW-1:0]    ms_r;
  logic              neg_r;
  logic [AW-1:0]     acc_r;
  logic [QW-1:0]     q_r;
  logic [W-1:0]      prod_r;

  logic [GAIN_W-1:0] g_mag;
  logic [W-1:0]      s_mag;
  logic [63:0]       pp;
  logic [AW-1:0]     acc_sum;
  logic [AW-1:0]     rnd;
  logic [QW-1:0]     q_nxt;
  logic [W-1:0]      prod_nxt;

  always_comb begin
    g_mag   = gain[GAIN_W-1] ? GAIN_W'(-gain) : GAIN_W'(gain);
    s_mag   = sig[W-1] ? W'(-sig) : W'(sig);
    pp      = mg_r * ms_r[MSW-1 -: 32];
    acc_sum = (acc_r << 32) + AW'(pp);
    rnd     = acc_r + ROUND_HALF;
    q_nxt   = QW'(rnd >> MUL_FRAC);
    if (!neg_r) begin
      prod_nxt = (q_r > Q_MAX) ? MAXW : q_r[W-1:0];
    end else begin
      prod_nxt = (q_r > Q_HALF) ? MINW : (~q_r[W-1:0]) + W'(1);
    end
  end

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_START;
    end else if (busy_r) begin
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
      end else begin
        cnt_nxt = cnt_r - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // accumulate chunks top first, then round, then sign and saturate
  always_ff @(posedge clk) begin
    if (start) begin
      mg_r  <= g_mag;
      ms_r  <= MSW'(s_mag);
      neg_r <= gain[GAIN_W-1] ^ sig[W-1];
      acc_r <= '0;
    end else if (busy_r) begin
      if (cnt_r > CW'(1)) begin
        acc_r <= acc_sum;
        ms_r  <= ms_r << 32;
      end else if (cnt_r == CW'(1)) begin
        q_r <= q_nxt;
      end else begin
        prod_r <= prod_nxt;
      end
    end
  end

  assign busy = busy_r;
  assign prod = signed'(prod_r);

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> (busy_r && cnt_r == CNT_START))
    else $error("multiplier did not start its sequence");

endmodule

[rtl/cpi_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpi_datapath
// Configuration registers, loop state, saturating add unit, shared multiplier
// and the output register of the cascaded PI controller.
// ----------------------------------------------------------------------------
module cpi_datapath import cpi_pkg::*; #(
  parameter int W = SIG_W_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  cpi_cmd_t               cmd,
  output cpi_status_t            status,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic                   cfg_valid,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  localparam int MW = ((W > IO_W) ? W : IO_W) + 1;
  localparam logic signed [MW-1:0] SIG_MAX = {{(MW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [MW-1:0] SIG_MIN = ~SIG_MAX;
  localparam logic signed [MW-1:0] O32_MAX = {{(MW-IO_W+1){1'b0}}, {(IO_W-1){1'b1}}};
  localparam logic signed [MW-1:0] O32_MIN = ~O32_MAX;
  localparam logic [W-1:0] MAXW = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] MINW = {1'b1, {(W-1){1'b0}}};

  function automatic logic signed [W-1:0] sat_add(input logic signed [W-1:0] a,
                                                  input logic signed [W-1:0] b,
                                                  input logic sub);
    logic [W:0] s;
    s = sub ? ({a[W-1], a} - {b[W-1], b}) : ({a[W-1], a} + {b[W-1], b});
    if (s[W] != s[W-1]) begin
      return s[W] ? MINW : MAXW;
    end
    return s[W-1:0];
  endfunction

  function automatic logic signed [W-1:0] to_sig(input logic signed [IO_W-1:0] x);
    logic signed [MW-1:0] ext;
    ext = {{(MW-IO_W){x[IO_W-1]}}, x};
    if (ext > SIG_MAX) return SIG_MAX[W-1:0];
    if (ext < SIG_MIN) return SIG_MIN[W-1:0];
    return ext[W-1:0];
  endfunction

  function automatic logic [IO_W-1:0] to_out(input logic signed [W-1:0] x);
    logic signed [MW-1:0] ext;
    ext = {{(MW-W){x[W-1]}}, x};
    if (ext > O32_MAX) return O32_MAX[IO_W-1:0];
    if (ext < O32_MIN) return O32_MIN[IO_W-1:0];
    return ext[IO_W-1:0];
  endfunction

  function automatic logic signed [W-1:0] lim_sig(input logic [LIMIT_W-1:0] l);
    logic signed [MW-1:0] ext;
    ext = {{(MW-LIMIT_W){1'b0}}, l};
    if (ext > SIG_MAX) return SIG_MAX[W-1:0];
    return ext[W-1:0];
  endfunction

  // configuration
  logic signed [GAIN_W-1:0] kp_o_r, recip_o_r, kp_i_r, recip_i_r;
  logic [DECAY_W-1:0]       decay_o_r, decay_i_r;
  logic [LIMIT_W-1:0]       limit_o_r, limit_i_r;

  // loop state
  logic signed [W-1:0] pe_o_r, pu_o_r, pus_o_r;
  logic signed [W-1:0] pe_i_r, pu_i_r, pus_i_r;

  // working registers
  logic signed [W-1:0] vref_r, vmeas_r, half_r, e_r, acc_r;
  logic signed [W-1:0] oraw_r, iraw_r;
  logic                oflag_r, iflag_r;
  logic                out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r;

  logic                     inner;
  logic signed [W-1:0]      sel_pe, sel_pu, sel_pus, lim, neg_lim, err_nxt, clamp_val;
  logic signed [GAIN_W-1:0] sel_kp, sel_recip, mul_gain;
  logic [DECAY_W-1:0]       sel_decay;
  logic [LIMIT_W-1:0]       sel_limit;
  logic                     clamp_hit, mul_start, mul_busy;
  logic signed [W-1:0]      prod;

  always_comb begin
    inner     = (cmd.loop == LOOP_INNER);
    sel_pe    = inner ? pe_i_r    : pe_o_r;
    sel_pu    = inner ? pu_i_r    : pu_o_r;
    sel_pus   = inner ? pus_i_r   : pus_o_r;
    sel_kp    = inner ? kp_i_r    : kp_o_r;
    sel_recip = inner ? recip_i_r : recip_o_r;
    sel_decay = inner ? decay_i_r : decay_o_r;
    sel_limit = inner ? limit_i_r : limit_o_r;
    err_nxt   = inner ? sat_add(pus_o_r, half_r, 1'b1) : sat_add(vref_r, vmeas_r, 1'b1);
    lim       = lim_sig(sel_limit);
    neg_lim   = -lim;
    clamp_val = acc_r;
    clamp_hit = 1'b0;
    if (acc_r > lim) begin
      clamp_val = lim;
      clamp_hit = 1'b1;
    end else if (acc_r < neg_lim) begin
      clamp_val = neg_lim;
      clamp_hit = 1'b1;
    end
    case (cmd.op)
      OP_MUL_RECIP: mul_gain = sel_recip;
      OP_MUL_DECAY: mul_gain = GAIN_W'(sel_decay);
      default:      mul_gain = sel_kp;
    endcase
    mul_start = (cmd.op == OP_MUL_RECIP) || (cmd.op == OP_MUL_DECAY) ||
                (cmd.op == OP_MUL_KP);
  end

  cpi_mul #(.W(W)) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .gain  (mul_gain),
    .sig   (acc_r),
    .busy  (mul_busy),
    .prod  (prod)
  );

  // control state, configuration and loop history
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kp_o_r      <= KP_OUTER_RST;
      recip_o_r   <= KP_OUTER_RECIP_RST;
      decay_o_r   <= DECAY_OUTER_RST;
      limit_o_r   <= LIMIT_OUTER_RST;
      kp_i_r      <= KP_INNER_RST;
      recip_i_r   <= KP_INNER_RECIP_RST;
      decay_i_r   <= DECAY_INNER_RST;
      limit_i_r   <= LIMIT_INNER_RST;
      pe_o_r      <= '0;
      pu_o_r      <= '0;
      pus_o_r     <= '0;
      pe_i_r      <= '0;
      pu_i_r      <= '0;
      pus_i_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          REG_KP_OUTER:       kp_o_r    <= signed'(cfg_data);
          REG_KP_OUTER_RECIP: recip_o_r <= signed'(cfg_data);
          REG_DECAY_OUTER:    decay_o_r <= cfg_data[DECAY_W-1:0];
          REG_LIMIT_OUTER:    limit_o_r <= cfg_data[LIMIT_W-1:0];
          REG_KP_INNER:       kp_i_r    <= signed'(cfg_data);
          REG_KP_INNER_RECIP: recip_i_r <= signed'(cfg_data);
          REG_DECAY_INNER:    decay_i_r <= cfg_data[DECAY_W-1:0];
          REG_LIMIT_INNER:    limit_i_r <= cfg_data[LIMIT_W-1:0];
          default: ;
        endcase
      end
      if (cmd.op == OP_COMMIT) begin
        if (inner) begin
          pe_i_r  <= e_r;
          pu_i_r  <= acc_r;
          pus_i_r <= clamp_val;
        end else begin
          pe_o_r  <= e_r;
          pu_o_r  <= acc_r;
          pus_o_r <= clamp_val;
        end
      end
      if (cmd.op == OP_EMIT) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        vref_r  <= to_sig(signed'(in_tdata[IO_W-1:0]));
        vmeas_r <= to_sig(signed'(in_tdata[2*IO_W-1:IO_W]));
        half_r  <= to_sig(signed'(in_tdata[3*IO_W-1:2*IO_W])) >>> 1;
      end
      OP_ERR:     e_r   <= err_nxt;
      OP_DIFF:    acc_r <= sat_add(sel_pus, sel_pu, 1'b1);
      OP_ADD_PE:  acc_r <= sat_add(sel_pe, prod, 1'b0);
      OP_SUB_E:   acc_r <= sat_add(e_r, prod, 1'b1);
      OP_ADD_PUS: acc_r <= sat_add(sel_pus, prod, 1'b0);
      OP_COMMIT: begin
        if (inner) begin
          iraw_r  <= acc_r;
          iflag_r <= clamp_hit;
        end else begin
          oraw_r  <= acc_r;
          oflag_r <= clamp_hit;
        end
      end
      OP_EMIT: begin
        out_data_r <= {{OUT_PAD_W{1'b0}}, iflag_r, oflag_r, to_out(iraw_r),
                       to_out(oraw_r), to_out(pus_o_r), to_out(pus_i_r)};
      end
      default: ;
    endcase
  end

  assign status.mul_busy = mul_busy;
  assign status.out_free = !out_valid_r || out_tready;
  assign out_tvalid      = out_valid_r;
  assign out_tdata       = out_data_r;

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_EMIT) |-> (!out_valid_r || out_tready))
    else $error("result overwrote an untaken result");

endmodule

[rtl/cpi_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpi_ctrl
// Sequencer of the cascaded PI controller: runs the outer loop, then the
// inner loop, then hands the result to the output register.
// ----------------------------------------------------------------------------
module cpi_ctrl import cpi_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  output cpi_cmd_t    cmd,
  input  cpi_status_t status
);

  cpi_state_t state_r, state_nxt;
  cpi_loop_t  loop_r, loop_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      loop_r  <= LOOP_OUTER;
    end else begin
      state_r <= state_nxt;
      loop_r  <= loop_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    loop_nxt  = loop_r;
    cmd.op    = OP_NONE;
    cmd.loop  = loop_r;
    in_tready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.op    = OP_LOAD;
          loop_nxt  = LOOP_OUTER;
          state_nxt = S_ERR;
        end
      end
      S_ERR: begin
        cmd.op    = OP_ERR;
        state_nxt = S_DIFF;
      end
      S_DIFF: begin
        cmd.op    = OP_DIFF;
        state_nxt = S_MUL_R;
      end
      S_MUL_R: begin
        cmd.op    = OP_MUL_RECIP;
        state_nxt = S_WAIT_R;
      end
      S_WAIT_R: begin
        if (!status.mul_busy) begin
          cmd.op    = OP_ADD_PE;
          state_nxt = S_MUL_D;
        end
      end
      S_MUL_D: begin
        cmd.op    = OP_MUL_DECAY;
        state_nxt = S_WAIT_D;
      end
      S_WAIT_D: begin
        if (!status.mul_busy) begin
          cmd.op    = OP_SUB_E;
          state_nxt = S_MUL_K;
        end
      end
      S_MUL_K: begin
        cmd.op    = OP_MUL_KP;
        state_nxt = S_WAIT_K;
      end
      S_WAIT_K: begin
        if (!status.mul_busy) begin
          cmd.op    = OP_ADD_PUS;
          state_nxt = S_COMMIT;
        end
      end
      S_COMMIT: begin
        cmd.op = OP_COMMIT;
        if (loop_r == LOOP_OUTER) begin
          loop_nxt  = LOOP_INNER;
          state_nxt = S_ERR;
        end else begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (status.out_free) begin
          cmd.op    = OP_EMIT;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  a_mul_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_MUL_RECIP || cmd.op == OP_MUL_DECAY || cmd.op == OP_MUL_KP)
      |-> !status.mul_busy)
    else $error("multiply issued while multiplier busy");

  a_load_outer: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_LOAD) |=> (state_r == S_ERR && loop_r == LOOP_OUTER))
    else $error("new request did not start with the outer loop");

endmodule

[rtl/cascaded_pi_antiwindup_controller_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cascaded_pi_antiwindup_controller_unit
// Cascaded voltage / current PI controller with back-calculation anti-windup.
// ----------------------------------------------------------------------------
// Requests: a new request is accepted only from idle, once the previous result has
//   been handed to the output register; the six products per sample go one after
//   another through one shared multiplier.
// Reset (rst_n, synchronous, active low): gains, decays and limits return to
//   their defaults, loop history clears to zero, the output register empties.
// ----------------------------------------------------------------------------
module cascaded_pi_antiwindup_controller_unit import cpi_pkg::*; #(
  parameter int SIGNAL_WIDTH = SIG_W_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // input request
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // voltage_ref, voltage_meas, current_meas
  // result request
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // duty, current_setpoint, outer_raw,
                                             // inner_raw, outer_clamped, inner_clamped
  // configuration write
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  cpi_cmd_t    cmd;
  cpi_status_t status;

  // Writes are always accepted and registered; unknown indexes are dropped by the register map.
  assign cfg_ready = 1'b1;

  // The sequencer holds in_tready high only while idle. Each loop runs:
  // error, back-calculation difference, three multiplies with their adds,
  // then a commit step that clamps and updates the loop history.
  cpi_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .cmd       (cmd),
    .status    (status)
  );

  // The output register decouples the two sides: a finished result may wait
  // there while the next request is accepted and worked on.
  cpi_datapath #(.W(SIGNAL_WIDTH)) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .status     (status),
    .in_tdata   (in_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
